>>> hw/rtl/cgb_pkg.sv
// Shared types and constants for the clipped glyph row blitter.
// Used by cgb_calc, cgb_out and clipped_glyph_row_blitter; no dependencies.
package cgb_pkg;

  // Default geometry
  localparam int LINE_BYTES       = 80;
  localparam int MAX_GLYPH_HEIGHT = 128;
  localparam int SCREEN_LINES     = 480;

  // Clip register reset values (full screen)
  localparam logic [9:0] CLIP_LEFT_RST   = 10'd0;
  localparam logic [8:0] CLIP_TOP_RST    = 9'd0;
  localparam logic [9:0] CLIP_WIDTH_RST  = 10'd640;
  localparam logic [8:0] CLIP_HEIGHT_RST = 9'd480;

  // Signed width for pixel and line arithmetic, covers every clip edge and origin
  localparam int CMP_W = 14;
  // Signed width of a byte column
  localparam int BC_W  = CMP_W - 3;
  // Signed width of the offset product before truncation
  localparam int OFF_W = CMP_W + 11;

  typedef enum logic [1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_WIDTH  = 2'd2,
    REG_CLIP_HEIGHT = 2'd3
  } cfg_reg_e;

  // Both candidate writes of one glyph row; a zero mask means no write
  typedef struct packed {
    logic [15:0] off_a;
    logic [15:0] off_b;
    logic [7:0]  mask_a;
    logic [7:0]  mask_b;
    logic [3:0]  color;
  } row_writes_t;

endpackage

>>> hw/rtl/cgb_calc.sv
// Combinational row evaluation: clip, italic slant, byte split and offsets.
// Depends on cgb_pkg.
module cgb_calc #(
  parameter int LineBytes      = cgb_pkg::LINE_BYTES,
  parameter int MaxGlyphHeight = cgb_pkg::MAX_GLYPH_HEIGHT,
  parameter int ScreenLines    = cgb_pkg::SCREEN_LINES
) (
  input  logic [9:0]               clip_left_i,
  input  logic [8:0]               clip_top_i,
  input  logic [9:0]               clip_width_i,
  input  logic [8:0]               clip_height_i,
  input  logic signed [10:0]       origin_x_i,
  input  logic signed [10:0]       origin_y_i,
  input  logic [6:0]               row_index_i,
  input  logic [7:0]               glyph_height_i,
  input  logic [7:0]               glyph_bits_i,
  input  logic                     italic_i,
  input  logic [3:0]               color_i,
  output cgb_pkg::row_writes_t     writes_o
);
  import cgb_pkg::*;

  localparam logic signed [CMP_W-1:0] SCR_W = CMP_W'(LineBytes * 8);
  localparam logic signed [CMP_W-1:0] SCR_H = CMP_W'(ScreenLines);
  localparam logic [8:0]              MAX_H = 9'(MaxGlyphHeight);
  localparam logic [10:0]             LB    = 11'(LineBytes);

  // Pixels of byte column bc that fall in [x0, x1), bit 7 leftmost
  function automatic logic [7:0] col_mask(input logic signed [BC_W-1:0]  bc,
                                          input logic signed [CMP_W-1:0] x0,
                                          input logic signed [CMP_W-1:0] x1);
    logic [7:0]              m;
    logic signed [CMP_W-1:0] sx;
    m = 8'h00;
    for (int b = 0; b < 8; b++) begin
      sx = $signed({bc, 3'(b)});
      m[3'(7 - b)] = (sx >= x0) && (sx < x1);
    end
    return m;
  endfunction

  logic signed [CMP_W-1:0] left, right, top, bottom;
  logic signed [CMP_W-1:0] x0, x1, y0, y1;
  logic signed [CMP_W-1:0] line, px;
  logic signed [BC_W-1:0]  bc, bc_next;
  logic signed [OFF_W-1:0] base;
  logic [8:0]              h_sat, row9, slant;
  logic [15:0]             spread;
  logic                    row_hit;

  always_comb begin
    left   = $signed(CMP_W'(clip_left_i));
    right  = $signed(CMP_W'(clip_left_i) + CMP_W'(clip_width_i));
    top    = $signed(CMP_W'(clip_top_i));
    bottom = $signed(CMP_W'(clip_top_i) + CMP_W'(clip_height_i));
    x0 = (left   < SCR_W) ? left   : SCR_W;
    x1 = (right  < SCR_W) ? right  : SCR_W;
    y0 = (top    < SCR_H) ? top    : SCR_H;
    y1 = (bottom < SCR_H) ? bottom : SCR_H;

    line    = CMP_W'(origin_y_i) + $signed(CMP_W'(row_index_i));
    row_hit = (line >= y0) && (line < y1);

    // Saturate height, then slant = (height - 1 - row) / 2 for rows inside the glyph
    h_sat = ({1'b0, glyph_height_i} > MAX_H) ? MAX_H : {1'b0, glyph_height_i};
    row9  = {2'b00, row_index_i};
    slant = (italic_i && (row9 < h_sat)) ? ((h_sat - 9'd1 - row9) >> 1) : 9'd0;

    px      = CMP_W'(origin_x_i) + $signed(CMP_W'(slant));
    bc      = $signed(px[CMP_W-1:3]);
    bc_next = bc + BC_W'(1);
    spread  = {glyph_bits_i, 8'h00} >> px[2:0];

    base = line * $signed({1'b0, LB}) + OFF_W'(bc);

    writes_o.off_a  = base[15:0];
    writes_o.off_b  = base[15:0] + 16'd1;
    writes_o.mask_a = spread[15:8] & col_mask(bc, x0, x1) & {8{row_hit}};
    writes_o.mask_b = spread[7:0] & col_mask(bc_next, x0, x1) & {8{row_hit}};
    writes_o.color  = color_i;
  end

endmodule

>>> hw/rtl/cgb_out.sv
// Two-slot result register: holds the writes of one row and drains them in order.
// Depends on cgb_pkg.
module cgb_out (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  cgb_pkg::row_writes_t writes_i,
  output logic                 free_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [15:0]          vram_offset_o,
  output logic [7:0]           write_mask_o,
  output logic [3:0]           pixel_color_o,
  output logic                 last_write_o
);
  import cgb_pkg::*;

  logic        a_q, a_d, b_q, b_d;
  logic [15:0] off_a_q, off_b_q;
  logic [7:0]  mask_a_q, mask_b_q;
  logic [3:0]  color_q;
  logic        fire;

  assign out_valid_o   = a_q | b_q;
  assign fire          = out_valid_o & out_ready_i;
  // Free when empty or the final pending write leaves this cycle
  assign free_o        = !(a_q || b_q) || (fire && !(a_q && b_q));
  assign vram_offset_o = a_q ? off_a_q : off_b_q;
  assign write_mask_o  = a_q ? mask_a_q : mask_b_q;
  assign pixel_color_o = color_q;
  assign last_write_o  = a_q ? !b_q : 1'b1;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    if (load_i) begin
      a_d = (writes_i.mask_a != 8'h00);
      b_d = (writes_i.mask_b != 8'h00);
    end else if (fire) begin
      if (a_q) begin
        a_d = 1'b0;
      end else begin
        b_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 1'b0;
      b_q <= 1'b0;
    end else begin
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      off_a_q  <= writes_i.off_a;
      off_b_q  <= writes_i.off_b;
      mask_a_q <= writes_i.mask_a;
      mask_b_q <= writes_i.mask_b;
      color_q  <= writes_i.color;
    end
  end

`ifndef SYNTHESIS
  a_nonzero_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (write_mask_o != 8'h00))
    else $error("presented write has an empty mask");

  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_q && b_q && fire) |=> (!a_q && b_q))
    else $error("second write lost after first transaction");

  a_adjacent_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_q && b_q) |-> (off_b_q == off_a_q + 16'd1))
    else $error("pending writes are not adjacent bytes");
`endif

endmodule

>>> hw/rtl/clipped_glyph_row_blitter.sv
// Flow: a row taken into the input register is evaluated from it and its writes are
// loaded into the result register; the second write goes out once the first is taken.
// Throughput: one row per cycle when it yields at most one write and the output is ready;
// a row with two writes holds the single output write port until both are taken.
// Reset: clip registers return to the full 640x480 screen and both stages empty.
// Depends on cgb_pkg, cgb_calc and cgb_out.
module clipped_glyph_row_blitter #(
  parameter int LineBytes      = cgb_pkg::LINE_BYTES,
  parameter int MaxGlyphHeight = cgb_pkg::MAX_GLYPH_HEIGHT,
  parameter int ScreenLines    = cgb_pkg::SCREEN_LINES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [9:0]         cfg_data_i,
  // Glyph row channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [10:0] origin_x_i,
  input  logic signed [10:0] origin_y_i,
  input  logic [6:0]         row_index_i,
  input  logic [7:0]         glyph_height_i,
  input  logic [7:0]         glyph_bits_i,
  input  logic               italic_i,
  input  logic [3:0]         color_i,
  // Frame buffer write channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        vram_offset_o,
  output logic [7:0]         write_mask_o,
  output logic [3:0]         pixel_color_o,
  output logic               last_write_o
);
  import cgb_pkg::*;

  // Clip rectangle registers
  logic [9:0] clip_left_q;
  logic [8:0] clip_top_q;
  logic [9:0] clip_width_q;
  logic [8:0] clip_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q   <= CLIP_LEFT_RST;
      clip_top_q    <= CLIP_TOP_RST;
      clip_width_q  <= CLIP_WIDTH_RST;
      clip_height_q <= CLIP_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_CLIP_LEFT:   clip_left_q   <= cfg_data_i;
        REG_CLIP_TOP:    clip_top_q    <= cfg_data_i[8:0];
        REG_CLIP_WIDTH:  clip_width_q  <= cfg_data_i;
        REG_CLIP_HEIGHT: clip_height_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Input register: one glyph row waiting for evaluation
  logic               s_valid_q, s_valid_d;
  logic signed [10:0] s_origin_x_q, s_origin_y_q;
  logic [6:0]         s_row_q;
  logic [7:0]         s_height_q, s_bits_q;
  logic               s_italic_q;
  logic [3:0]         s_color_q;

  row_writes_t writes;
  logic        out_free;
  logic        no_writes;
  logic        advance;
  logic        load;
  logic        in_fire;

  cgb_calc #(
    .LineBytes      (LineBytes),
    .MaxGlyphHeight (MaxGlyphHeight),
    .ScreenLines    (ScreenLines)
  ) u_calc (
    .clip_left_i    (clip_left_q),
    .clip_top_i     (clip_top_q),
    .clip_width_i   (clip_width_q),
    .clip_height_i  (clip_height_q),
    .origin_x_i     (s_origin_x_q),
    .origin_y_i     (s_origin_y_q),
    .row_index_i    (s_row_q),
    .glyph_height_i (s_height_q),
    .glyph_bits_i   (s_bits_q),
    .italic_i       (s_italic_q),
    .color_i        (s_color_q),
    .writes_o       (writes)
  );

  // A fully clipped row leaves at once; otherwise wait for the result register
  assign no_writes  = (writes.mask_a == 8'h00) && (writes.mask_b == 8'h00);
  assign advance    = s_valid_q && (out_free || no_writes);
  assign load       = s_valid_q && out_free;
  assign in_ready_o = !s_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s_valid_d = s_valid_q;
    if (in_fire) begin
      s_valid_d = 1'b1;
    end else if (advance) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  // Capture the transaction payload; hold it while the row waits
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s_origin_x_q <= origin_x_i;
      s_origin_y_q <= origin_y_i;
      s_row_q      <= row_index_i;
      s_height_q   <= glyph_height_i;
      s_bits_q     <= glyph_bits_i;
      s_italic_q   <= italic_i;
      s_color_q    <= color_i;
    end
  end

  cgb_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .writes_i      (writes),
    .free_o        (out_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .vram_offset_o (vram_offset_o),
    .write_mask_o  (write_mask_o),
    .pixel_color_o (pixel_color_o),
    .last_write_o  (last_write_o)
  );

`ifndef SYNTHESIS
  a_hold_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_q && !advance) |=> (s_valid_q && $stable(s_bits_q) && $stable(s_origin_x_q)))
    else $error("waiting row was lost or overwritten");

  a_stall_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s_valid_q && out_valid_o && !no_writes))
    else $error("input stalled with no pending work");
`endif

endmodule

>>> dv/clipped_glyph_row_blitter_tb.sv
// Self-checking testbench for clipped_glyph_row_blitter: glyph rows in, frame buffer writes out.
// A directed table runs first, then random rows under several clip windows, with random stalls.
// Depends on cgb_pkg and the RTL of the blitter.
module clipped_glyph_row_blitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cgb_pkg::*;

  localparam int SCR_W   = LINE_BYTES * 8;
  localparam int PREDICT = -1;  // table rows that leave the expectation to the predictor

  typedef struct {
    logic signed [10:0] ox;
    logic signed [10:0] oy;
    logic [6:0]         row;
    logic [7:0]         hgt;
    logic [7:0]         pix;
    logic               ital;
    logic [3:0]         color;
  } glyph_row_t;

  typedef struct {
    logic [15:0] off;
    logic [7:0]  mask;
    logic [3:0]  color;
    logic        last;
  } fb_write_t;

  typedef enum logic {STEP_ROW, STEP_REG} step_kind_e;

  // One line of the directed table: either a register write or a glyph row, the row
  // optionally carrying its expected writes (n = PREDICT hands it to the predictor)
  typedef struct {
    step_kind_e  kind;
    cfg_reg_e    regsel;
    logic [9:0]  val;
    glyph_row_t  r;
    int          n;
    logic [15:0] off0;
    logic [7:0]  m0;
    logic [15:0] off1;
    logic [7:0]  m1;
  } plan_step_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [1:0]         cfg_addr_i     = '0;
  logic [9:0]         cfg_data_i     = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_ready_o;
  logic signed [10:0] origin_x_i     = '0;
  logic signed [10:0] origin_y_i     = '0;
  logic [6:0]         row_index_i    = '0;
  logic [7:0]         glyph_height_i = '0;
  logic [7:0]         glyph_bits_i   = '0;
  logic               italic_i       = 1'b0;
  logic [3:0]         color_i        = '0;
  logic               out_valid_o;
  logic               out_ready_i    = 1'b0;
  logic [15:0]        vram_offset_o;
  logic [7:0]         write_mask_o;
  logic [3:0]         pixel_color_o;
  logic               last_write_o;

  // Shadow copy of the clip registers, updated when a write lands
  int clip_x = CLIP_LEFT_RST;
  int clip_y = CLIP_TOP_RST;
  int clip_w = CLIP_WIDTH_RST;
  int clip_h = CLIP_HEIGHT_RST;

  fb_write_t  writes_due[$];      // frame buffer writes still owed by the block, oldest first
  plan_step_t directed_steps[$];
  int         mismatches = 0;
  bit         steady     = 1'b0;  // suppress idling on both channels

  clipped_glyph_row_blitter u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .row_index_i    (row_index_i),
    .glyph_height_i (glyph_height_i),
    .glyph_bits_i   (glyph_bits_i),
    .italic_i       (italic_i),
    .color_i        (color_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .vram_offset_o  (vram_offset_o),
    .write_mask_o   (write_mask_o),
    .pixel_color_o  (pixel_color_o),
    .last_write_o   (last_write_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clip window edges after saturation to the screen
  function automatic void clip_edges(output int x0, output int x1, output int y0, output int y1);
    x0 = (clip_x < SCR_W) ? clip_x : SCR_W;
    x1 = (clip_x + clip_w < SCR_W) ? clip_x + clip_w : SCR_W;
    y0 = (clip_y < SCREEN_LINES) ? clip_y : SCREEN_LINES;
    y1 = (clip_y + clip_h < SCREEN_LINES) ? clip_y + clip_h : SCREEN_LINES;
  endfunction

  // Pixels of byte column bcol that fall inside [x0, x1), bit 7 leftmost
  function automatic logic [7:0] span_mask(input int bcol, input int x0, input int x1);
    logic [7:0] m;
    int         sx;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      sx = bcol * 8 + b;
      if (sx >= x0 && sx < x1) m[7-b] = 1'b1;
    end
    return m;
  endfunction

  // Work out the writes one glyph row turns into under the current clip window
  function automatic void blit_row(input glyph_row_t r, output int n,
                                   output logic [15:0] off0, output logic [7:0] m0,
                                   output logic [15:0] off1, output logic [7:0] m1);
    int          x0, x1, y0, y1, fb_line, hgt, slant, px, bcol, shift;
    logic [7:0]  lo, hi;
    logic [15:0] base;
    clip_edges(x0, x1, y0, y1);
    n = 0;
    off0 = '0;
    m0 = '0;
    off1 = '0;
    m1 = '0;
    fb_line = int'($signed(r.oy)) + int'(r.row);
    if (fb_line < y0 || fb_line >= y1) return;
    hgt = (int'(r.hgt) > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : int'(r.hgt);
    slant = (r.ital && int'(r.row) < hgt) ? (hgt - 1 - int'(r.row)) / 2 : 0;
    px = int'($signed(r.ox)) + slant;
    // bias keeps the division a floor for negative columns
    bcol = (px + 2048) / 8 - 256;
    shift = (px + 2048) % 8;
    base = 16'(fb_line * LINE_BYTES + bcol);
    lo = (r.pix >> shift) & span_mask(bcol, x0, x1);
    hi = (shift == 0) ? 8'h00 : 8'(r.pix << (8 - shift)) & span_mask(bcol + 1, x0, x1);
    if (lo != 0) begin
      off0 = base;
      m0 = lo;
      n = 1;
    end
    if (hi != 0) begin
      if (n == 0) begin
        off0 = base + 16'd1;
        m0 = hi;
      end else begin
        off1 = base + 16'd1;
        m1 = hi;
      end
      n++;
    end
  endfunction

  // Append the writes of one row; the final one carries the last flag
  function automatic void queue_writes(input int n, input logic [15:0] off0,
                                       input logic [7:0] m0, input logic [15:0] off1,
                                       input logic [7:0] m1, input logic [3:0] color);
    if (n >= 1) writes_due.push_back('{off0, m0, color, n == 1});
    if (n == 2) writes_due.push_back('{off1, m1, color, 1'b1});
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void plan_row(input int ox, input int oy, input int row, input int hgt,
                                   input int pix, input int ital, input int color,
                                   input int n, input int off0 = 0, input int m0 = 0,
                                   input int off1 = 0, input int m1 = 0);
    plan_step_t st;
    st.kind     = STEP_ROW;
    st.regsel   = REG_CLIP_LEFT;
    st.val      = '0;
    st.r.ox     = 11'(ox);
    st.r.oy     = 11'(oy);
    st.r.row    = 7'(row);
    st.r.hgt    = 8'(hgt);
    st.r.pix    = 8'(pix);
    st.r.ital   = 1'(ital);
    st.r.color  = 4'(color);
    st.n        = n;
    st.off0     = 16'(off0);
    st.m0       = 8'(m0);
    st.off1     = 16'(off1);
    st.m1       = 8'(m1);
    directed_steps.push_back(st);
  endfunction

  function automatic void plan_reg(input cfg_reg_e sel, input int val);
    plan_step_t st;
    st = '{STEP_REG, sel, 10'(val), '{'0, '0, '0, '0, '0, 1'b0, '0}, 0, '0, '0, '0, '0};
    directed_steps.push_back(st);
  endfunction

  // Random row aimed mostly at the clip window, with a share of raw noise
  function automatic glyph_row_t random_row();
    glyph_row_t r;
    int         x0, x1, y0, y1, hgt, row, tx, ty;
    clip_edges(x0, x1, y0, y1);
    if (x1 <= x0 || y1 <= y0) begin
      x0 = 0;
      x1 = SCR_W;
      y0 = 0;
      y1 = SCREEN_LINES;
    end
    if ($urandom_range(0, 9) == 0) begin
      hgt = $urandom_range(0, 255);
      row = $urandom_range(0, 127);
    end else begin
      hgt = $urandom_range(1, MAX_GLYPH_HEIGHT);
      row = $urandom_range(0, hgt - 1);
    end
    r.hgt   = 8'(hgt);
    r.row   = 7'(row);
    r.pix   = 8'($urandom_range(0, 255));
    r.ital  = 1'($urandom_range(0, 1));
    r.color = 4'($urandom_range(0, 15));
    ty = int'($urandom_range(0, y1 - y0 + 3)) + y0 - 2 - row;
    tx = int'($urandom_range(0, x1 - x0 + 12)) + x0 - 10;
    if ($urandom_range(0, 4) == 0 || ty < -1024 || ty > 1023) r.oy = 11'($urandom_range(0, 2047));
    else r.oy = 11'(ty);
    if ($urandom_range(0, 4) == 0 || tx < -1024 || tx > 1023) r.ox = 11'($urandom_range(0, 2047));
    else r.ox = 11'(tx);
    return r;
  endfunction

  // Present one row and hold it until the block takes it; returns at the accepting edge
  task automatic send_row(input glyph_row_t r);
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    origin_x_i     <= r.ox;
    origin_y_i     <= r.oy;
    row_index_i    <= r.row;
    glyph_height_i <= r.hgt;
    glyph_bits_i   <= r.pix;
    italic_i       <= r.ital;
    color_i        <= r.color;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait for every owed write, then let a dropped row drain from the pipe
  task automatic settle();
    in_valid_i <= 1'b0;
    while (writes_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_clip(input cfg_reg_e sel, input logic [9:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= sel;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      REG_CLIP_LEFT:   clip_x = int'(val);
      REG_CLIP_TOP:    clip_y = int'(val[8:0]);
      REG_CLIP_WIDTH:  clip_w = int'(val);
      REG_CLIP_HEIGHT: clip_h = int'(val[8:0]);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Write channel: random back-pressure and in-order compare against the owed writes
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    fb_write_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (writes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected write: off %0d mask %02h color %0d last %0b",
                   vram_offset_o, write_mask_o, pixel_color_o, last_write_o);
      end else begin
        w = writes_due.pop_front();
        if (vram_offset_o !== w.off || write_mask_o !== w.mask ||
            pixel_color_o !== w.color || last_write_o !== w.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("write mismatch: exp off %0d mask %02h color %0d last %0b, got off %0d mask %02h color %0d last %0b",
                     w.off, w.mask, w.color, w.last,
                     vram_offset_o, write_mask_o, pixel_color_o, last_write_o);
        end
      end
    end
    // stall at random with a 20 percent chance, never during the steady stretch
    out_ready_i <= steady || ($urandom_range(0, 99) >= 20);
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    plan_step_t  st;
    glyph_row_t  r;
    int          n, l, t, w, h;
    logic [15:0] o0, o1;
    logic [7:0]  k0, k1;

    // Directed table under the reset window: corners, both origin extremes, byte splits,
    // a row whose left byte falls off-screen, empty pixels and the italic slant cases
    plan_row(0, 0, 0, 8, 'hFF, 0, 15, 1, 0, 'hFF);
    plan_row(632, 479, 0, 1, 'h81, 0, 0, 1, 38399, 'h81);
    plan_row(-1024, -1024, 0, 1, 'hFF, 0, 9, 0);
    plan_row(1023, 1023, 127, 255, 'hFF, 1, 5, 0);
    plan_row(3, 8, 2, 8, 'hFF, 0, 7, 2, 800, 'h1F, 801, 'hE0);
    plan_row(-3, 0, 0, 8, 'hFF, 0, 3, 1, 0, 'hF8);
    plan_row(637, 0, 0, 8, 'hFF, 0, 12, 1, 79, 'h07);
    plan_row(100, 100, 3, 8, 'h00, 0, 6, 0);
    plan_row(0, 0, 0, 8, 'h80, 1, 4, PREDICT);
    plan_row(17, 20, 0, 255, 'hC3, 1, 8, PREDICT);   // height saturates
    plan_row(9, 40, 10, 5, 'hFF, 1, 11, PREDICT);    // row past the glyph: no slant
    plan_row(21, 50, 0, 0, 'hA5, 1, 13, PREDICT);
    plan_row(16, 60, 0, 17, 'h3C, 1, 14, PREDICT);   // slant of a whole byte stays aligned
    plan_row(200, 352, 127, 128, 'h5A, 1, 10, PREDICT);
    plan_row(-5, -1, 1, 16, 'hFF, 1, 1, PREDICT);
    plan_row(1023, 0, 0, 8, 'hFF, 0, 2, PREDICT);
    plan_row(-1024, 100, 0, 255, 'hFF, 1, 2, PREDICT);
    plan_row(300, 200, 64, 128, 'h55, 0, 2, PREDICT);
    // Small window: columns 4..11, lines 2..4
    plan_reg(REG_CLIP_LEFT, 4);
    plan_reg(REG_CLIP_TOP, 2);
    plan_reg(REG_CLIP_WIDTH, 8);
    plan_reg(REG_CLIP_HEIGHT, 3);
    plan_row(0, 2, 0, 8, 'hFF, 0, 5, PREDICT);
    plan_row(4, 4, 0, 8, 'hFF, 0, 6, PREDICT);
    plan_row(2, 5, 0, 8, 'hFF, 0, 7, PREDICT);
    plan_row(6, 1, 0, 8, 'hFF, 0, 8, PREDICT);
    // Zero width: nothing gets through
    plan_reg(REG_CLIP_WIDTH, 0);
    plan_row(4, 3, 0, 8, 'hFF, 0, 9, 0);
    // Every register at its maximum: window starts past the screen
    plan_reg(REG_CLIP_LEFT, 1023);
    plan_reg(REG_CLIP_TOP, 511);
    plan_reg(REG_CLIP_WIDTH, 1023);
    plan_reg(REG_CLIP_HEIGHT, 511);
    plan_row(632, 479, 0, 8, 'hFF, 0, 3, 0);
    // Oversized window from the origin saturates to the full screen
    plan_reg(REG_CLIP_LEFT, 0);
    plan_reg(REG_CLIP_TOP, 0);
    plan_row(632, 479, 0, 8, 'hFF, 0, 3, 1, 38399, 'hFF);
    plan_row(636, 0, 0, 8, 'hFF, 0, 3, PREDICT);
    // Single pixel in the bottom-right corner
    plan_reg(REG_CLIP_LEFT, 639);
    plan_reg(REG_CLIP_TOP, 479);
    plan_reg(REG_CLIP_WIDTH, 1);
    plan_reg(REG_CLIP_HEIGHT, 1);
    plan_row(632, 479, 0, 8, 'hFF, 0, 15, 1, 38399, 'h01);
    plan_row(639, 479, 0, 8, 'h80, 0, 15, 1, 38399, 'h01);

    // Hold reset, then release it on a clock edge
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      st = directed_steps[i];
      if (st.kind == STEP_REG) begin
        settle();
        write_clip(st.regsel, st.val);
      end else begin
        send_row(st.r);
        if (st.n == PREDICT) begin
          blit_row(st.r, n, o0, k0, o1, k1);
          queue_writes(n, o0, k0, o1, k1, st.r.color);
        end else begin
          queue_writes(st.n, st.off0, st.m0, st.off1, st.m1, st.r.color);
        end
      end
    end

    // Random phases, each under its own clip window; phase 3 runs without any idling
    for (int ph = 0; ph < 11; ph++) begin
      settle();
      case (ph)
        0: begin
          l = CLIP_LEFT_RST; t = CLIP_TOP_RST; w = CLIP_WIDTH_RST; h = CLIP_HEIGHT_RST;
        end
        1: begin
          l = 0; t = 0; w = 1023; h = 511;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: begin
              l = $urandom_range(0, 639); t = $urandom_range(0, 479);
              w = $urandom_range(0, 640); h = $urandom_range(0, 480);
            end
            1: begin
              l = $urandom_range(0, 639); t = $urandom_range(0, 479);
              w = $urandom_range(1, 40);  h = $urandom_range(1, 20);
            end
            2: begin
              l = $urandom_range(0, 1023); t = $urandom_range(0, 511);
              w = $urandom_range(0, 1023); h = $urandom_range(0, 511);
            end
            default: begin
              l = CLIP_LEFT_RST; t = CLIP_TOP_RST; w = CLIP_WIDTH_RST; h = CLIP_HEIGHT_RST;
            end
          endcase
        end
      endcase
      write_clip(REG_CLIP_LEFT, 10'(l));
      write_clip(REG_CLIP_TOP, 10'(t));
      write_clip(REG_CLIP_WIDTH, 10'(w));
      write_clip(REG_CLIP_HEIGHT, 10'(h));
      steady = (ph == 3);
      repeat (150) begin
        r = random_row();
        send_row(r);
        blit_row(r, n, o0, k0, o1, k1);
        queue_writes(n, o0, k0, o1, k1, r.color);
      end
    end
    steady = 1'b0;

    // Drain every owed write, then watch the pipe for any stray one
    settle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
